// File: design/trc_pkg.sv
`default_nettype none

package trc_pkg;

  // Sizes of the timer unit.
  localparam int NUM_CHANNELS  = 3;
  localparam int COUNTER_WIDTH = 32;
  localparam int DATA_W        = 32;
  localparam int SEL_W         = 4;
  localparam int CTRL_W        = 10;
  localparam int PRE_W         = 8;
  localparam int PEND_W        = 8;
  localparam int IRQ_W         = 3;
  localparam int BYTE_W        = 8;

  // Bus commands.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  // Register map.
  localparam logic [SEL_W-1:0] SEL_OUTCTL = 4'd0;
  localparam logic [SEL_W-1:0] SEL_START  = 4'd1;

  typedef enum logic [1:0] {
    GRP_CONST = 2'd0,
    GRP_COUNT = 2'd1,
    GRP_CTRL  = 2'd2,
    GRP_NONE  = 2'd3
  } grp_t;

  // Control word fields.
  localparam int                CTRL_UNIE_BIT = 5;
  localparam int                CTRL_UNF_BIT  = 8;
  localparam logic [CTRL_W-1:0] CTRL_BAD      = 10'h2dc;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SEL_W-1:0]  reg_sel;
    logic [DATA_W-1:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [IRQ_W-1:0]  irq_lines;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    grp_t       grp;
    logic [1:0] ch;
  } sel_dec_t;

  // Actions for one channel in the current step.
  typedef struct packed {
    logic              tick;
    logic              wr_reload;
    logic              wr_count;
    logic              wr_ctrl;
    logic [DATA_W-1:0] wdata;
  } chan_cmd_t;

  // Channel contents; pend_nz reflects the pending count after the step.
  typedef struct packed {
    logic [COUNTER_WIDTH-1:0] reload;
    logic [COUNTER_WIDTH-1:0] count;
    logic [CTRL_W-1:0]        ctrl;
    logic                     pend_nz;
  } chan_view_t;

  // Splits a channel register select into its group and channel.
  function automatic sel_dec_t sel_decode(input logic [SEL_W-1:0] sel);
    sel_dec_t d;
    d.grp = GRP_NONE;
    d.ch  = 2'd0;
    case (sel)
      4'd2:    begin d.grp = GRP_CONST; d.ch = 2'd0; end
      4'd3:    begin d.grp = GRP_CONST; d.ch = 2'd1; end
      4'd4:    begin d.grp = GRP_CONST; d.ch = 2'd2; end
      4'd5:    begin d.grp = GRP_COUNT; d.ch = 2'd0; end
      4'd6:    begin d.grp = GRP_COUNT; d.ch = 2'd1; end
      4'd7:    begin d.grp = GRP_COUNT; d.ch = 2'd2; end
      4'd8:    begin d.grp = GRP_CTRL;  d.ch = 2'd0; end
      4'd9:    begin d.grp = GRP_CTRL;  d.ch = 2'd1; end
      4'd10:   begin d.grp = GRP_CTRL;  d.ch = 2'd2; end
      default: begin d.grp = GRP_NONE;  d.ch = 2'd0; end
    endcase
    return d;
  endfunction

  // Terminal prescaler value for divide by 4, 16, 64 and 256.
  function automatic logic [PRE_W-1:0] prescale_limit(input logic [1:0] psel);
    logic [PRE_W-1:0] lim;
    case (psel)
      2'd0:    lim = 8'd3;
      2'd1:    lim = 8'd15;
      2'd2:    lim = 8'd63;
      default: lim = 8'd255;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// File: design/trc_channel.sv
`default_nettype none

module trc_channel import trc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chan_cmd_t  cmd,
  output chan_view_t      view
);

  logic [COUNTER_WIDTH-1:0] reload_r, reload_nxt;
  logic [COUNTER_WIDTH-1:0] count_r, count_nxt;
  logic [CTRL_W-1:0]        ctrl_r, ctrl_nxt;
  logic [PRE_W-1:0]         pre_r, pre_nxt;
  logic [PEND_W-1:0]        pend_r, pend_nxt;
  logic [PRE_W-1:0]         limit;

  assign limit = prescale_limit(ctrl_r[1:0]);

  always_comb begin
    reload_nxt = reload_r;
    count_nxt  = count_r;
    ctrl_nxt   = ctrl_r;
    pre_nxt    = pre_r;
    pend_nxt   = pend_r;
    if (cmd.tick) begin
      if (pre_r < limit) begin
        pre_nxt = pre_r + 1'b1;
      end else begin
        pre_nxt = '0;
        if (count_r == '0) begin
          // Underflow: reload, flag it and count a pending interrupt.
          count_nxt              = reload_r;
          ctrl_nxt[CTRL_UNF_BIT] = 1'b1;
          if (ctrl_r[CTRL_UNIE_BIT] && (pend_r != '1)) begin
            pend_nxt = pend_r + 1'b1;
          end
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
    if (cmd.wr_reload) begin
      reload_nxt = cmd.wdata[COUNTER_WIDTH-1:0];
    end
    if (cmd.wr_count) begin
      count_nxt = cmd.wdata[COUNTER_WIDTH-1:0];
    end
    if (cmd.wr_ctrl) begin
      // Clearing a set underflow flag acknowledges one pending interrupt.
      if (ctrl_r[CTRL_UNF_BIT] && !cmd.wdata[CTRL_UNF_BIT] && (pend_r != '0)) begin
        pend_nxt = pend_r - 1'b1;
      end
      ctrl_nxt = cmd.wdata[CTRL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '1;
      count_r  <= '1;
      ctrl_r   <= '0;
      pre_r    <= '0;
      pend_r   <= '0;
    end else begin
      reload_r <= reload_nxt;
      count_r  <= count_nxt;
      ctrl_r   <= ctrl_nxt;
      pre_r    <= pre_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign view.reload  = reload_r;
  assign view.count   = count_r;
  assign view.ctrl    = ctrl_r;
  assign view.pend_nz = (pend_nxt != '0);

endmodule

`default_nettype wire

// File: design/reload_down_counter_timer_unit_core.sv
`default_nettype none

// Three-channel reload down-counter timer behind a small register map. Each
// input beat is a peripheral-clock tick, a register read or a register write,
// and every beat produces exactly one result beat carrying the read data, the
// per-channel interrupt lines as they stand after that beat, and a status code.
// The block takes one beat per clock while the result register is free or
// being emptied: an accepted beat is held in the input register, is applied
// to the channel registers in a single pass and moves into the result
// register when it advances. The result register is what decouples the
// two sides; a held result stalls the input register, and only then does
// in_ready drop.
// Channel state changes at the edge that loads the result, so the next beat
// always sees the effect of the previous one.
module reload_down_counter_timer_unit_core import trc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // Input register.
  in_item_t  in_r;
  logic      in_valid_r, in_valid_nxt;

  // Result register.
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // Global registers: start bits and the stored-only output control.
  logic [BYTE_W-1:0] start_r, start_nxt;
  logic [BYTE_W-1:0] outctl_r, outctl_nxt;

  logic       advance;
  cmd_t       cmd;
  logic       is_acc, is_wr;
  sel_dec_t   dec;
  logic       ch_ok;
  logic       bad_ctrl;
  logic [DATA_W-1:0] rd_mux;

  chan_cmd_t  chan_cmd  [NUM_CHANNELS];
  chan_view_t chan_view [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] hit;

  // The held beat moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Decode of the held beat.
  assign cmd      = cmd_t'(in_r.cmd);
  assign is_acc   = (cmd == CMD_READ) || (cmd == CMD_WRITE);
  assign is_wr    = (cmd == CMD_WRITE);
  assign dec      = sel_decode(in_r.reg_sel);
  assign ch_ok    = (dec.grp != GRP_NONE) && (int'(dec.ch) < NUM_CHANNELS);
  assign bad_ctrl = |(in_r.wdata[CTRL_W-1:0] & CTRL_BAD);

  // One timer channel per instance; a channel only sees actions when the
  // beat actually advances, so its state holds otherwise.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    assign hit[i] = is_acc && ch_ok && (int'(dec.ch) == i);

    assign chan_cmd[i].tick      = advance && (cmd == CMD_TICK) && start_r[i];
    assign chan_cmd[i].wr_reload = advance && hit[i] && is_wr && (dec.grp == GRP_CONST);
    assign chan_cmd[i].wr_count  = advance && hit[i] && is_wr && (dec.grp == GRP_COUNT);
    assign chan_cmd[i].wr_ctrl   = advance && hit[i] && is_wr && (dec.grp == GRP_CTRL)
                                   && !bad_ctrl;
    assign chan_cmd[i].wdata     = in_r.wdata;

    trc_channel u_chan (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (chan_cmd[i]),
      .view (chan_view[i])
    );
  end

  // Read data from the addressed channel register.
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (hit[i]) begin
        case (dec.grp)
          GRP_CONST: rd_mux = DATA_W'(chan_view[i].reload);
          GRP_COUNT: rd_mux = DATA_W'(chan_view[i].count);
          GRP_CTRL:  rd_mux = DATA_W'(chan_view[i].ctrl);
          default:   rd_mux = '0;
        endcase
      end
    end
  end

  // Result of the held beat and the global register updates.
  always_comb begin
    start_nxt         = start_r;
    outctl_nxt        = outctl_r;
    out_nxt.rdata     = '0;
    out_nxt.irq_lines = '0;
    out_nxt.status    = ST_OK;
    if (is_acc) begin
      if (in_r.reg_sel == SEL_OUTCTL) begin
        if (is_wr) begin
          if (advance) begin
            outctl_nxt = in_r.wdata[BYTE_W-1:0];
          end
        end else begin
          out_nxt.rdata = DATA_W'(outctl_r);
        end
      end else if (in_r.reg_sel == SEL_START) begin
        if (is_wr) begin
          if (advance) begin
            start_nxt = in_r.wdata[BYTE_W-1:0];
          end
        end else begin
          out_nxt.rdata = DATA_W'(start_r);
        end
      end else if (!ch_ok) begin
        out_nxt.status = ST_UNMAPPED;
      end else if (is_wr && (dec.grp == GRP_CTRL) && bad_ctrl) begin
        out_nxt.status = ST_REJECTED;
      end else if (!is_wr) begin
        out_nxt.rdata = rd_mux;
      end
    end
    // Interrupt lines follow the pending counts after this beat.
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (i < IRQ_W) begin
        out_nxt.irq_lines[i] = chan_view[i].pend_nz;
      end
    end
  end

  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      outctl_r    <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      outctl_r    <= outctl_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A held beat that cannot move on must block the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |-> !in_ready)
    else $error("input accepted while the held beat is stalled");

  // A new result only ever comes from a beat that advanced.
  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result appeared without an advancing beat");

  // A rejected control write to channel 0 leaves its control word alone.
  a_reject_keeps_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_wr && (dec.grp == GRP_CTRL) && (dec.ch == 2'd0) && bad_ctrl)
    |=> $stable(chan_view[0].ctrl))
    else $error("rejected control write changed the control word");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the three-channel reload down-counter timer.
//
// Every input beat (tick, register read or register write) yields exactly one
// result beat. The bench keeps its own copy of the timer state and works out
// each expected result at the edge where the beat is accepted. Expectations
// wait in a queue, and the monitor compares every result beat with the
// oldest one, field by field.
//
// The run has three stretches:
//   * a short table of directed beats covering reset values, the register
//     map, unmapped and rejected accesses, the unused command, a first
//     underflow and the clearing of its flag;
//   * a random stretch, mostly well-formed traffic on small counter
//     values so that channels underflow often, with some noise mixed in;
//   * a burst of back-to-back ticks with every channel reloading from zero,
//     which drives the pending counts into saturation, followed by a few
//     flag clears that bring them down again.
// Both sides of the block idle at random. Once, the receiver holds off for a
// long stretch while the sender keeps offering beats, so the block fills up
// and has to stall its input.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trc_pkg::*;

  // Register indexes that the package does not name.
  localparam logic [SEL_W-1:0] REG_CONST0  = 4'd2;
  localparam logic [SEL_W-1:0] REG_CONST2  = 4'd4;
  localparam logic [SEL_W-1:0] REG_COUNT0  = 4'd5;
  localparam logic [SEL_W-1:0] REG_COUNT2  = 4'd7;
  localparam logic [SEL_W-1:0] REG_CTRL0   = 4'd8;
  localparam logic [SEL_W-1:0] REG_CTRL1   = 4'd9;
  localparam logic [SEL_W-1:0] REG_CTRL2   = 4'd10;
  localparam logic [SEL_W-1:0] REG_HOLE_LO = 4'd11;
  localparam logic [SEL_W-1:0] REG_HOLE_HI = 4'd15;
  localparam int               GROUP_STRIDE = 3;

  // Control word values used in directed traffic.
  localparam logic [CTRL_W-1:0] CTRL_UNIE = 10'h020;
  localparam logic [CTRL_W-1:0] CTRL_UNF  = 10'h100;

  localparam int RANDOM_BEATS   = 200;
  localparam int SATURATE_TICKS = 1040;  // 260 underflows at divide by 4
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 100;   // results checked before the long hold
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 200;

  typedef struct {
    in_item_t  beat;
    bit        typed;   // expected result written into the table
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  reload_down_counter_timer_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the timer state, kept up to date as beats are accepted.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]        start_reg;
  logic [BYTE_W-1:0]        outctl_reg;
  logic [COUNTER_WIDTH-1:0] reload_reg [NUM_CHANNELS];
  logic [COUNTER_WIDTH-1:0] count_reg  [NUM_CHANNELS];
  logic [CTRL_W-1:0]        ctrl_reg   [NUM_CHANNELS];
  logic [PRE_W-1:0]         presc_reg  [NUM_CHANNELS];
  logic [PEND_W-1:0]        pend_reg   [NUM_CHANNELS];

  out_item_t awaited_replies [$];
  stim_row_t directed_rows [$];

  // While calm is set neither side inserts idle cycles.
  bit calm = 1'b0;

  int beats_sent       = 0;
  int results_checked  = 0;
  int mismatches       = 0;
  int underflows       = 0;
  int saturated_hits   = 0;
  int flag_clears      = 0;
  int rejected_writes  = 0;
  int quiet_cycles     = 0;

  // One peripheral-clock tick for one channel. The prescaler counts up to its
  // terminal value and wraps; a prescaler left above the terminal value by a
  // change of divisor wraps on the next tick. Only then does the counter move.
  function automatic void tick_timer(int ch);
    int unsigned lim;
    if (!start_reg[ch]) return;
    lim = (4 << (2 * ctrl_reg[ch][1:0])) - 1;
    if (presc_reg[ch] < lim) begin
      presc_reg[ch]++;
      return;
    end
    presc_reg[ch] = '0;
    if (count_reg[ch] == '0) begin
      // Wrap from zero: reload, raise the flag, count a pending interrupt.
      count_reg[ch] = reload_reg[ch];
      ctrl_reg[ch][CTRL_UNF_BIT] = 1'b1;
      underflows++;
      if (ctrl_reg[ch][CTRL_UNIE_BIT]) begin
        if (pend_reg[ch] != '1) pend_reg[ch]++;
        else saturated_hits++;
      end
    end else begin
      count_reg[ch]--;
    end
  endfunction

  // Applies one beat to the shadow state and returns the result it causes.
  function automatic out_item_t predict_timer_beat(in_item_t b);
    out_item_t r;
    grp_t      grp;
    int        off, ch, i;
    bit        wr;
    r        = '0;
    r.status = ST_OK;
    wr       = (b.cmd == CMD_WRITE);
    if (b.cmd == CMD_TICK) begin
      for (i = 0; i < NUM_CHANNELS; i++) tick_timer(i);
    end else if (b.cmd == CMD_READ || wr) begin
      if (b.reg_sel == SEL_OUTCTL) begin
        if (wr) outctl_reg = b.wdata[BYTE_W-1:0];
        else r.rdata = DATA_W'(outctl_reg);
      end else if (b.reg_sel == SEL_START) begin
        if (wr) start_reg = b.wdata[BYTE_W-1:0];
        else r.rdata = DATA_W'(start_reg);
      end else if (b.reg_sel >= REG_CONST0 && b.reg_sel <= REG_CTRL2) begin
        off = b.reg_sel - REG_CONST0;
        grp = grp_t'(off / GROUP_STRIDE);
        ch  = off % GROUP_STRIDE;
        if (ch >= NUM_CHANNELS) begin
          r.status = ST_UNMAPPED;
        end else begin
          case (grp)
            GRP_CONST: begin
              if (wr) reload_reg[ch] = b.wdata[COUNTER_WIDTH-1:0];
              else r.rdata = DATA_W'(reload_reg[ch]);
            end
            GRP_COUNT: begin
              if (wr) count_reg[ch] = b.wdata[COUNTER_WIDTH-1:0];
              else r.rdata = DATA_W'(count_reg[ch]);
            end
            default: begin
              if (!wr) begin
                r.rdata = DATA_W'(ctrl_reg[ch]);
              end else if ((b.wdata[CTRL_W-1:0] & CTRL_BAD) != '0) begin
                // Any unimplemented bit rejects the whole write.
                r.status = ST_REJECTED;
                rejected_writes++;
              end else begin
                // Writing the flag as zero while it is set acknowledges one
                // pending interrupt.
                if (ctrl_reg[ch][CTRL_UNF_BIT] && !b.wdata[CTRL_UNF_BIT] &&
                    pend_reg[ch] != '0) begin
                  pend_reg[ch]--;
                  flag_clears++;
                end
                ctrl_reg[ch] = b.wdata[CTRL_W-1:0];
              end
            end
          endcase
        end
      end else begin
        r.status = ST_UNMAPPED;
      end
    end
    for (i = 0; i < NUM_CHANNELS && i < IRQ_W; i++)
      r.irq_lines[i] = (pend_reg[i] != '0);
    return r;
  endfunction

  function automatic in_item_t mk_beat(cmd_t c, logic [SEL_W-1:0] s,
                                       logic [DATA_W-1:0] d);
    in_item_t b;
    b.cmd     = c;
    b.reg_sel = s;
    b.wdata   = d;
    return b;
  endfunction

  // Typed rows expect no interrupt line, as they all precede the first
  // underflow.
  function automatic void add_row(cmd_t c, logic [SEL_W-1:0] s, logic [DATA_W-1:0] d,
                                  bit typed, logic [DATA_W-1:0] rd, status_t st);
    stim_row_t row;
    row.beat           = mk_beat(c, s, d);
    row.typed          = typed;
    row.want           = '0;
    row.want.rdata     = rd;
    row.want.status    = st;
    directed_rows.push_back(row);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random traffic: half ticks, then reads, well-formed writes with small
  // counter values so that underflows come often, and a little noise.
  function automatic in_item_t random_beat();
    in_item_t         b;
    int unsigned      pick, kind;
    logic [SEL_W-1:0] ch;
    logic [CTRL_W-1:0] bad;
    b.cmd     = CMD_TICK;
    b.reg_sel = SEL_W'($urandom_range(0, 15));   // ignored on a tick
    b.wdata   = $urandom();
    ch        = SEL_W'($urandom_range(0, NUM_CHANNELS - 1));
    pick      = $urandom_range(0, 99);
    kind      = $urandom_range(0, 9);
    if (pick < 50) return b;
    if (pick < 70) begin
      b.cmd     = CMD_READ;
      b.reg_sel = SEL_W'($urandom_range(0, REG_CTRL2));
      return b;
    end
    if (pick < 92) begin
      b.cmd = CMD_WRITE;
      if (kind < 4) begin
        // Legal control word; fast divisors and the interrupt enable favoured.
        b.reg_sel = REG_CTRL0 + ch;
        b.wdata   = b.wdata & ~32'(CTRL_BAD);
        if ($urandom_range(0, 3) != 0) b.wdata[1:0] = 2'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) b.wdata[CTRL_UNIE_BIT] = 1'b1;
      end else if (kind < 7 || kind == 9) begin
        b.reg_sel = ((kind == 5 || kind == 6) ? REG_COUNT0 : REG_CONST0) + ch;
        if ($urandom_range(0, 7) != 0) b.wdata = $urandom_range(0, 12);
      end else if (kind == 7) begin
        b.reg_sel = SEL_START;
        if ($urandom_range(0, 1) != 0) b.wdata[NUM_CHANNELS-1:0] = '1;
      end else begin
        b.reg_sel = SEL_OUTCTL;
      end
      return b;
    end
    case (kind % 3)
      0: b.cmd = CMD_NONE;
      1: begin
        b.cmd     = ($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ;
        b.reg_sel = SEL_W'($urandom_range(REG_HOLE_LO, REG_HOLE_HI));
      end
      default: begin
        // Control write carrying at least one unimplemented bit.
        bad = CTRL_BAD & CTRL_W'($urandom());
        if (bad == '0) bad = CTRL_BAD;
        b.cmd     = CMD_WRITE;
        b.reg_sel = REG_CTRL0 + ch;
        b.wdata[CTRL_W-1:0] = b.wdata[CTRL_W-1:0] | bad;
      end
    endcase
    return b;
  endfunction

  // Offers one beat, holds it until the handshake and records what it must
  // produce. Returns in the time step of the accepting edge.
  task automatic send_beat(input in_item_t b, input bit typed, input out_item_t want);
    out_item_t predicted;
    int        gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_timer_beat(b);
    awaited_replies.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  task automatic report_field(string field, logic [DATA_W-1:0] want_v,
                              logic [DATA_W-1:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: directed table, random stretch, saturation burst, then the end.
  // ---------------------------------------------------------------------------
  initial begin : drive_beats
    out_item_t        none;
    logic [SEL_W-1:0] ch;
    int               i;
    none       = '0;
    start_reg  = '0;
    outctl_reg = '0;
    for (i = 0; i < NUM_CHANNELS; i++) begin
      reload_reg[i] = '1;
      count_reg[i]  = '1;
      ctrl_reg[i]   = '0;
      presc_reg[i]  = '0;
      pend_reg[i]   = '0;
    end

    // Reset values straight after reset.
    add_row(CMD_READ,  SEL_START,   '0,            1, '0,            ST_OK);
    add_row(CMD_READ,  REG_CONST0,  '0,            1, 32'hffffffff,  ST_OK);
    add_row(CMD_READ,  REG_COUNT2,  '0,            1, 32'hffffffff,  ST_OK);
    add_row(CMD_READ,  REG_CTRL1,   '0,            1, '0,            ST_OK);
    // Holes in the register map, read and written.
    add_row(CMD_READ,  REG_HOLE_LO, '0,            1, '0,            ST_UNMAPPED);
    add_row(CMD_WRITE, REG_HOLE_HI, 32'hffffffff,  1, '0,            ST_UNMAPPED);
    // Unimplemented control bits: all of them, then the capture flag alone.
    add_row(CMD_WRITE, REG_CTRL0,   32'(CTRL_BAD), 1, '0,            ST_REJECTED);
    add_row(CMD_WRITE, REG_CTRL0,   32'h00000200,  1, '0,            ST_REJECTED);
    // The unused command does nothing at all.
    add_row(CMD_NONE,  SEL_START,   32'hffffffff,  1, '0,            ST_OK);
    // Wide data into byte registers keeps only the low byte.
    add_row(CMD_WRITE, SEL_OUTCTL,  32'hffffffff,  1, '0,            ST_OK);
    add_row(CMD_READ,  SEL_OUTCTL,  '0,            1, 32'h000000ff,  ST_OK);
    // Channel 0 from zero with a zero constant, interrupt on, divide by 4.
    add_row(CMD_WRITE, REG_CONST0,  '0,            1, '0,            ST_OK);
    add_row(CMD_WRITE, REG_COUNT0,  '0,            1, '0,            ST_OK);
    add_row(CMD_WRITE, REG_CTRL0,   32'(CTRL_UNIE), 1, '0,           ST_OK);
    // Start bits above the channel count are stored and read back.
    add_row(CMD_WRITE, SEL_START,   32'hffffffff,  1, '0,            ST_OK);
    add_row(CMD_READ,  SEL_START,   '0,            1, 32'h000000ff,  ST_OK);
    // Four ticks: the fourth wraps the prescaler and underflows channel 0.
    repeat (4) add_row(CMD_TICK, SEL_OUTCTL, 32'hffffffff, 0, '0, ST_OK);
    add_row(CMD_READ,  REG_CTRL0,   '0,            0, '0,            ST_OK);
    // Clearing the flag drops the pending count and the line.
    add_row(CMD_WRITE, REG_CTRL0,   32'(CTRL_UNIE), 0, '0,           ST_OK);
    // Writing the flag as one sets it; divide by 256 on channel 1.
    add_row(CMD_WRITE, REG_CTRL1,   32'(CTRL_UNF | CTRL_UNIE | 10'h003), 0, '0, ST_OK);
    add_row(CMD_WRITE, REG_CONST2,  32'h5a5aa5a5,  0, '0,            ST_OK);
    add_row(CMD_READ,  REG_CONST2,  '0,            0, '0,            ST_OK);
    add_row(CMD_TICK,  REG_HOLE_HI, '0,            0, '0,            ST_OK);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);

    // Random stretch; every hundred beats or so both sides run without gaps.
    for (i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i % 100) >= 80;
      send_beat(random_beat(), 1'b0, none);
    end

    // Saturation burst: every channel reloads from zero at divide by 4, so a
    // long run of ticks pushes each pending count past its ceiling.
    calm = 1'b1;
    send_beat(mk_beat(CMD_WRITE, SEL_START, '0), 1'b0, none);
    for (i = 0; i < NUM_CHANNELS; i++) begin
      ch = SEL_W'(i);
      send_beat(mk_beat(CMD_WRITE, REG_CONST0 + ch, '0), 1'b0, none);
      send_beat(mk_beat(CMD_WRITE, REG_COUNT0 + ch, '0), 1'b0, none);
      send_beat(mk_beat(CMD_WRITE, REG_CTRL0 + ch, 32'(CTRL_UNIE)), 1'b0, none);
    end
    send_beat(mk_beat(CMD_WRITE, SEL_START, 32'h00000007), 1'b0, none);
    for (i = 0; i < SATURATE_TICKS; i++)
      send_beat(mk_beat(CMD_TICK, SEL_OUTCTL, '0), 1'b0, none);
    calm = 1'b0;

    // Walk the saturated counts down a little: clear, then set again, three times over.
    for (i = 0; i < NUM_CHANNELS; i++) begin
      ch = SEL_W'(i);
      repeat (3) begin
        send_beat(mk_beat(CMD_WRITE, REG_CTRL0 + ch, 32'(CTRL_UNIE)), 1'b0, none);
        send_beat(mk_beat(CMD_WRITE, REG_CTRL0 + ch, 32'(CTRL_UNIE | CTRL_UNF)),
                  1'b0, none);
      end
      send_beat(mk_beat(CMD_READ, REG_CTRL0 + ch, '0), 1'b0, none);
      send_beat(mk_beat(CMD_READ, REG_COUNT0 + ch, '0), 1'b0, none);
    end

    // Drain, then leave time for any stray result beat to show up.
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d beats: directed table, %0d random beats and a saturating burst;",
             beats_sent, RANDOM_BEATS);
    $display("%0d results checked, %0d underflows, %0d saturated hits,",
             results_checked, underflows, saturated_hits);
    $display("%0d flag clears, %0d rejected writes.", flag_clears, rejected_writes);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, with one long hold-off part way through
  // the random stretch so the result register fills and in_ready drops.
  // ---------------------------------------------------------------------------
  initial begin : drive_out_ready
    int stall;
    bit held_long;
    held_long = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_long && results_checked >= HOLD_AFTER) begin
        held_long = 1'b1;
        stall     = LONG_HOLD;
      end else if (calm) begin
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking. Every accepted result beat is matched against the oldest
  // awaited result; a beat with nothing awaited is a failure in itself.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing awaited, rdata %h irq %b status %0d",
                 $time, out_data.rdata, out_data.irq_lines, out_data.status);
      end else begin
        want = awaited_replies.pop_front();
        if (out_data.rdata !== want.rdata)
          report_field("rdata", want.rdata, out_data.rdata);
        if (out_data.irq_lines !== want.irq_lines)
          report_field("irq_lines", DATA_W'(want.irq_lines), DATA_W'(out_data.irq_lines));
        if (out_data.status !== want.status)
          report_field("status", DATA_W'(want.status), DATA_W'(out_data.status));
        results_checked++;
      end
    end
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results still awaited",
               $time, QUIET_LIMIT, awaited_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
